// ----- hdl/ghem_pkg.sv -----
// Shared types and constants of the GNSS health event monitor.
// Holds the record, statistics and state structs and the event codes.
// No dependencies; compile first.
package ghem_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned SatW   = 8;
  localparam int unsigned HdopW  = 16;
  localparam int unsigned FixW   = 3;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned VelW   = 16;
  localparam int unsigned AltW   = 21;
  localparam int unsigned CntW   = 16;
  localparam int unsigned RecW   = 32;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Up to five events per record: low-sat, warning, two from critical, fix.
  localparam int unsigned MaxEv = 5;
  localparam int unsigned EvIdxW = $clog2(MaxEv);

  typedef enum logic [CodeW-1:0] {
    EV_NONE          = 4'd0,
    EV_LOWSAT_BEGIN  = 4'd1,
    EV_LOWSAT_END    = 4'd2,
    EV_WARN_BEGIN    = 4'd3,
    EV_WARN_END      = 4'd4,
    EV_CRIT_BEGIN    = 4'd5,
    EV_CRIT_END      = 4'd6,
    EV_FIXLOSS_BEGIN = 4'd7,
    EV_FIXLOSS_END   = 4'd8
  } ev_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_SAT_LIMIT   = 2'd0,
    CFG_HDOP_WARN_LEVEL = 2'd1,
    CFG_HDOP_CRIT_LEVEL = 2'd2,
    CFG_MIN_FIX_TYPE    = 2'd3
  } cfg_idx_e;

  typedef ev_code_e [MaxEv-1:0] ev_list_t;

  typedef struct packed {
    logic [SatW-1:0]  low_sat_limit;
    logic [HdopW-1:0] hdop_warn_level;
    logic [HdopW-1:0] hdop_crit_level;
    logic [FixW-1:0]  min_fix_type;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    low_sat_limit:   8'd6,
    hdop_warn_level: 16'd250,
    hdop_crit_level: 16'd500,
    min_fix_type:    3'd2
  };

  typedef struct packed {
    logic                     first_of_log;
    logic [TimeW-1:0]         time_us;
    logic [SatW-1:0]          sat_count;
    logic [HdopW-1:0]         hdop;
    logic [FixW-1:0]          fix_kind;
    logic [SpeedW-1:0]        speed;
    logic signed [VelW-1:0]   vel_down;
    logic signed [AltW-1:0]   altitude;
  } rec_t;

  typedef struct packed {
    logic [CntW-1:0]        warn_total;
    logic [CntW-1:0]        crit_total;
    logic [SpeedW-1:0]      peak_speed;
    logic signed [VelW-1:0] peak_climb;
    logic signed [VelW-1:0] peak_descent;
    logic [SatW-1:0]        most_sats;
    logic [SatW-1:0]        fewest_sats;
    logic [AltW-1:0]        peak_alt_gain;
    logic [RecW-1:0]        records_seen;
  } stats_t;

  typedef struct packed {
    logic                   low_sat_active;
    logic                   hdop_warn_active;
    logic                   hdop_crit_active;
    logic                   fix_lost_active;
    logic [TimeW-1:0]       start_time;
    logic signed [AltW-1:0] base_altitude;
    stats_t                 stats;
  } state_t;

  localparam state_t StateClear = '{
    low_sat_active:   1'b0,
    hdop_warn_active: 1'b0,
    hdop_crit_active: 1'b0,
    fix_lost_active:  1'b0,
    start_time:       '0,
    base_altitude:    '0,
    stats: '{
      warn_total:    '0,
      crit_total:    '0,
      peak_speed:    '0,
      peak_climb:    '0,
      peak_descent:  '0,
      most_sats:     '0,
      fewest_sats:   8'd255,
      peak_alt_gain: '0,
      records_seen:  '0
    }
  };

endpackage

// ----- hdl/ghem_if.sv -----
// Valid/ready channel interfaces for GNSS records and monitor results.
// Depends on ghem_pkg for field widths.
interface ghem_rec_if;
  import ghem_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   first_of_log;
  logic [TimeW-1:0]       time_us;
  logic [SatW-1:0]        sat_count;
  logic [HdopW-1:0]       hdop;
  logic [FixW-1:0]        fix_kind;
  logic [SpeedW-1:0]      speed;
  logic signed [VelW-1:0] vel_down;
  logic signed [AltW-1:0] altitude;

  modport source (output valid, first_of_log, time_us, sat_count, hdop, fix_kind, speed,
                  vel_down, altitude, input ready);
  modport sink (input valid, first_of_log, time_us, sat_count, hdop, fix_kind, speed,
                vel_down, altitude, output ready);
endinterface

interface ghem_res_if;
  import ghem_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CodeW-1:0]       event_code;
  logic [TimeW-1:0]       event_time_us;
  logic                   last_of_run;
  logic [CntW-1:0]        warn_total;
  logic [CntW-1:0]        crit_total;
  logic [SpeedW-1:0]      peak_speed;
  logic signed [VelW-1:0] peak_climb;
  logic signed [VelW-1:0] peak_descent;
  logic [SatW-1:0]        most_sats;
  logic [SatW-1:0]        fewest_sats;
  logic [AltW-1:0]        peak_alt_gain;
  logic [RecW-1:0]        records_seen;

  modport source (output valid, event_code, event_time_us, last_of_run, warn_total,
                  crit_total, peak_speed, peak_climb, peak_descent, most_sats, fewest_sats,
                  peak_alt_gain, records_seen, input ready);
  modport sink (input valid, event_code, event_time_us, last_of_run, warn_total,
                crit_total, peak_speed, peak_climb, peak_descent, most_sats, fewest_sats,
                peak_alt_gain, records_seen, output ready);
endinterface

// ----- hdl/ghem_eval.sv -----
// Single-pass judgement of one record: condition latches, event list,
// counters and running extremes. Purely combinational; depends on ghem_pkg.
module ghem_eval (
  input  ghem_pkg::cfg_t                 cfg_i,
  input  ghem_pkg::state_t               state_i,
  input  ghem_pkg::rec_t                 rec_i,
  output ghem_pkg::state_t               state_o,
  output ghem_pkg::ev_list_t             ev_o,
  output logic [ghem_pkg::EvIdxW-1:0]    ev_cnt_o,
  output logic [ghem_pkg::TimeW-1:0]     elapsed_o
);
  import ghem_pkg::*;

  state_t                 cur;
  state_t                 nxt;
  ev_list_t               ev;
  logic [EvIdxW-1:0]      n;
  logic [2:0]             warn_inc;
  logic [1:0]             crit_inc;
  logic                   low_sat;
  logic                   fix_low;
  logic                   warn_band;
  logic                   crit_band;
  logic                   low_band;
  logic [CntW:0]          warn_sum;
  logic [CntW:0]          crit_sum;
  logic signed [AltW:0]   gain;

  always_comb begin
    cur = state_i;
    if (rec_i.first_of_log) begin
      cur                    = StateClear;
      cur.start_time         = rec_i.time_us;
      cur.base_altitude      = rec_i.altitude;
      cur.stats.peak_speed   = rec_i.speed;
      cur.stats.peak_climb   = rec_i.vel_down;
      cur.stats.peak_descent = rec_i.vel_down;
      cur.stats.most_sats    = rec_i.sat_count;
    end

    nxt      = cur;
    ev       = '{default: EV_NONE};
    n        = '0;
    warn_inc = '0;
    crit_inc = '0;

    low_sat   = rec_i.sat_count < cfg_i.low_sat_limit;
    fix_low   = rec_i.fix_kind < cfg_i.min_fix_type;
    warn_band = (rec_i.hdop > cfg_i.hdop_warn_level) && (rec_i.hdop < cfg_i.hdop_crit_level);
    crit_band = rec_i.hdop >= cfg_i.hdop_crit_level;
    low_band  = rec_i.hdop <= cfg_i.hdop_warn_level;

    if (low_sat && !cur.low_sat_active) begin
      ev[n] = EV_LOWSAT_BEGIN; n = n + 1'b1;
      warn_inc = warn_inc + 1'b1;
      nxt.low_sat_active = 1'b1;
    end else if (!low_sat && cur.low_sat_active) begin
      ev[n] = EV_LOWSAT_END; n = n + 1'b1;
      nxt.low_sat_active = 1'b0;
    end

    // Warning to critical drops the warning latch silently but still counts both.
    priority if (warn_band && !cur.hdop_warn_active) begin
      ev[n] = EV_WARN_BEGIN; n = n + 1'b1;
      warn_inc = warn_inc + 1'b1;
      nxt.hdop_warn_active = 1'b1;
    end else if (crit_band && cur.hdop_warn_active) begin
      warn_inc = warn_inc + 1'b1;
      crit_inc = crit_inc + 1'b1;
      nxt.hdop_warn_active = 1'b0;
    end else if (low_band && cur.hdop_warn_active) begin
      ev[n] = EV_WARN_END; n = n + 1'b1;
      nxt.hdop_warn_active = 1'b0;
    end else begin
    end

    // Leaving critical into the warning band repeats a warning begin.
    priority if (crit_band && !cur.hdop_crit_active) begin
      ev[n] = EV_CRIT_BEGIN; n = n + 1'b1;
      warn_inc = warn_inc + 1'b1;
      crit_inc = crit_inc + 1'b1;
      nxt.hdop_crit_active = 1'b1;
    end else if (warn_band && cur.hdop_crit_active) begin
      ev[n] = EV_CRIT_END; n = n + 1'b1;
      ev[n] = EV_WARN_BEGIN; n = n + 1'b1;
      warn_inc = warn_inc + 1'b1;
      nxt.hdop_crit_active = 1'b0;
      nxt.hdop_warn_active = 1'b1;
    end else if (low_band && cur.hdop_crit_active) begin
      ev[n] = EV_CRIT_END; n = n + 1'b1;
      nxt.hdop_crit_active = 1'b0;
    end else begin
    end

    if (fix_low && !cur.fix_lost_active) begin
      ev[n] = EV_FIXLOSS_BEGIN; n = n + 1'b1;
      warn_inc = warn_inc + 1'b1;
      crit_inc = crit_inc + 1'b1;
      nxt.fix_lost_active = 1'b1;
    end else if (!fix_low && cur.fix_lost_active) begin
      ev[n] = EV_FIXLOSS_END; n = n + 1'b1;
      nxt.fix_lost_active = 1'b0;
    end

    // A quiet record still yields one result.
    if (n == '0) begin
      n = EvIdxW'(1);
    end

    // Repeated saturating bumps equal one clamped add.
    warn_sum = {1'b0, cur.stats.warn_total} + {{(CntW-2){1'b0}}, warn_inc};
    crit_sum = {1'b0, cur.stats.crit_total} + {{(CntW-1){1'b0}}, crit_inc};
    nxt.stats.warn_total = warn_sum[CntW] ? '1 : warn_sum[CntW-1:0];
    nxt.stats.crit_total = crit_sum[CntW] ? '1 : crit_sum[CntW-1:0];

    if (rec_i.speed > cur.stats.peak_speed)     nxt.stats.peak_speed   = rec_i.speed;
    if (rec_i.vel_down < cur.stats.peak_climb)  nxt.stats.peak_climb   = rec_i.vel_down;
    if (rec_i.vel_down > cur.stats.peak_descent) nxt.stats.peak_descent = rec_i.vel_down;
    if (rec_i.sat_count > cur.stats.most_sats)  nxt.stats.most_sats    = rec_i.sat_count;
    if (rec_i.sat_count < cur.stats.fewest_sats) nxt.stats.fewest_sats = rec_i.sat_count;

    gain = {rec_i.altitude[AltW-1], rec_i.altitude}
         - {cur.base_altitude[AltW-1], cur.base_altitude};
    if (!gain[AltW] && (gain != '0) && (gain[AltW-1:0] > cur.stats.peak_alt_gain)) begin
      nxt.stats.peak_alt_gain = gain[AltW-1:0];
    end

    if (cur.stats.records_seen != '1) begin
      nxt.stats.records_seen = cur.stats.records_seen + 1'b1;
    end
  end

  assign state_o   = nxt;
  assign ev_o      = ev;
  assign ev_cnt_o  = n;
  assign elapsed_o = rec_i.time_us - cur.start_time;

endmodule

// ----- hdl/gnss_health_event_monitor.sv -----
// Top level of the GNSS health event monitor: configuration registers,
// record register, state and result buffer. Depends on ghem_pkg, ghem_if, ghem_eval.
//
// Usage:
//   rec_i takes one GNSS record per transaction; res_o gives one to five
//   results per record, the last marked by last_of_run. Every result of a
//   record carries the same elapsed time and statistics as they stand after
//   that record; event_code differs. A record that raises nothing yields one
//   result with event code none.
//   Order: an accepted record waits in the record register, then moves into
//   the result buffer, which presents its results on res_o.
//   Throughput: the result buffer drains one result per cycle on res_o while
//   res_o.ready is high, and takes the next record as its last result goes. The
//   record register takes the next record while the buffer drains, and the
//   evaluation is one registered pass.
//   Stall: a stalled res_o holds the current result; the record register
//   then fills and rec_i.ready falls until the buffer moves on.
//   Reset: thresholds return to 6, 250, 500 and 2, latches and statistics
//   clear, fewest_sats returns to 255; no clearing pass is needed.
//   Configuration: cfg_we_i writes cfg_wdata_i into the register at
//   cfg_idx_i; write only while the block is idle.
module gnss_health_event_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ghem_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ghem_pkg::CfgW-1:0]      cfg_wdata_i,
  ghem_rec_if.sink                       rec_i,
  ghem_res_if.source                     res_o
);
  import ghem_pkg::*;

  cfg_t               cfg_q;
  state_t             state_q;
  state_t             state_d;
  rec_t               rec_q;
  logic               rec_vld_q;
  ev_list_t           ev_q;
  ev_list_t           ev_d;
  logic [EvIdxW-1:0]  cnt_q;
  logic [EvIdxW-1:0]  cnt_d;
  logic [EvIdxW-1:0]  idx_q;
  logic [TimeW-1:0]   elapsed_q;
  logic [TimeW-1:0]   elapsed_d;
  stats_t             stats_q;
  logic               res_vld_q;
  logic               in_fire;
  logic               out_fire;
  logic               last;
  logic               res_free;
  logic               move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_SAT_LIMIT:   cfg_q.low_sat_limit   <= cfg_wdata_i[SatW-1:0];
        CFG_HDOP_WARN_LEVEL: cfg_q.hdop_warn_level <= cfg_wdata_i[HdopW-1:0];
        CFG_HDOP_CRIT_LEVEL: cfg_q.hdop_crit_level <= cfg_wdata_i[HdopW-1:0];
        CFG_MIN_FIX_TYPE:    cfg_q.min_fix_type    <= cfg_wdata_i[FixW-1:0];
        default:             cfg_q <= cfg_q;
      endcase
    end
  end

  assign in_fire  = rec_i.valid && rec_i.ready;
  assign out_fire = res_vld_q && res_o.ready;
  assign last     = (idx_q == cnt_q - 1'b1);
  assign res_free = !res_vld_q || (out_fire && last);
  assign move     = rec_vld_q && res_free;

  assign rec_i.ready = !rec_vld_q || move;

  ghem_eval u_eval (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .rec_i     (rec_q),
    .state_o   (state_d),
    .ev_o      (ev_d),
    .ev_cnt_o  (cnt_d),
    .elapsed_o (elapsed_d)
  );

  // Record register: hold until the result buffer frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q <= 1'b0;
    end else if (in_fire) begin
      rec_vld_q <= 1'b1;
    end else if (move) begin
      rec_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rec_q <= '{
        first_of_log: rec_i.first_of_log,
        time_us:      rec_i.time_us,
        sat_count:    rec_i.sat_count,
        hdop:         rec_i.hdop,
        fix_kind:     rec_i.fix_kind,
        speed:        rec_i.speed,
        vel_down:     rec_i.vel_down,
        altitude:     rec_i.altitude
      };
    end
  end

  // Advance the monitor state as a record enters the result buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateClear;
      res_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (move) begin
      state_q   <= state_d;
      res_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (out_fire && last) begin
      res_vld_q <= 1'b0;
    end else if (out_fire) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      ev_q      <= ev_d;
      cnt_q     <= cnt_d;
      elapsed_q <= elapsed_d;
      stats_q   <= state_d.stats;
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.event_code    = ev_q[idx_q];
  assign res_o.event_time_us = elapsed_q;
  assign res_o.last_of_run   = last;
  assign res_o.warn_total    = stats_q.warn_total;
  assign res_o.crit_total    = stats_q.crit_total;
  assign res_o.peak_speed    = stats_q.peak_speed;
  assign res_o.peak_climb    = stats_q.peak_climb;
  assign res_o.peak_descent  = stats_q.peak_descent;
  assign res_o.most_sats     = stats_q.most_sats;
  assign res_o.fewest_sats   = stats_q.fewest_sats;
  assign res_o.peak_alt_gain = stats_q.peak_alt_gain;
  assign res_o.records_seen  = stats_q.records_seen;

endmodule

// ----- hdl/ghem_checker.sv -----
// Port-level checks on the result channel of the monitor, bound to the top.
// Depends on ghem_pkg and gnss_health_event_monitor.
module ghem_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic                          res_last_i,
  input logic [ghem_pkg::CodeW-1:0]    res_code_i,
  input logic [ghem_pkg::TimeW-1:0]    res_time_i,
  input logic [ghem_pkg::CntW-1:0]     res_warn_i,
  input logic [ghem_pkg::RecW-1:0]     res_records_i
);
  import ghem_pkg::*;

  // A stalled result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // The rest of a record follows straight after a non-final transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=> res_valid_i)
    else $error("record results broken up");

  // Results of one record share time, warn_total and records_seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_last_i |=>
      $stable(res_time_i) && $stable(res_warn_i) && $stable(res_records_i))
    else $error("statistics changed within a record");

  // A no-event result is always the last of its record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_code_i == EV_NONE) |-> res_last_i)
    else $error("no-event result not final");

endmodule

bind gnss_health_event_monitor ghem_checker u_ghem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_last_i    (res_o.last_of_run),
  .res_code_i    (res_o.event_code),
  .res_time_i    (res_o.event_time_us),
  .res_warn_i    (res_o.warn_total),
  .res_records_i (res_o.records_seen)
);

// ----- dv/testbench.sv -----
// Self-checking bench for gnss_health_event_monitor: directed records, then random logs
// over several threshold settings. A scoreboard class mirrors the monitor's state.
// Depends on ghem_pkg, ghem_if and gnss_health_event_monitor from the hdl folder.
module testbench;
  import ghem_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned HoldOff    = 90;

  typedef struct packed {
    ev_code_e         code;
    logic [TimeW-1:0] elapsed;
    logic             last;
    stats_t           stats;
  } outcome_t;

  class health_scoreboard;
    cfg_t        thresholds;
    state_t      mirror;
    outcome_t    due_results[$];
    int unsigned errors;
    int unsigned records;
    int unsigned results;
    int unsigned code_seen[9];

    function new();
      thresholds = CfgReset;
      mirror     = StateClear;
    endfunction

    function void set_threshold(cfg_idx_e idx, logic [CfgW-1:0] value);
      case (idx)
        CFG_LOW_SAT_LIMIT:   thresholds.low_sat_limit   = value[SatW-1:0];
        CFG_HDOP_WARN_LEVEL: thresholds.hdop_warn_level = value[HdopW-1:0];
        CFG_HDOP_CRIT_LEVEL: thresholds.hdop_crit_level = value[HdopW-1:0];
        default:             thresholds.min_fix_type    = value[FixW-1:0];
      endcase
    endfunction

    function void bump_warn();
      if (mirror.stats.warn_total != '1) mirror.stats.warn_total++;
    endfunction

    function void bump_crit();
      if (mirror.stats.crit_total != '1) mirror.stats.crit_total++;
    endfunction

    // Advance the mirrored state by one record and queue the results it causes.
    function void note_record(rec_t r);
      ev_code_e evs[$];
      logic     warn_band;
      logic     crit_band;
      logic     low_band;
      int       gain;
      outcome_t o;
      if (r.first_of_log) begin
        mirror = StateClear;
        mirror.start_time         = r.time_us;
        mirror.base_altitude      = r.altitude;
        mirror.stats.peak_speed   = r.speed;
        mirror.stats.peak_climb   = r.vel_down;
        mirror.stats.peak_descent = r.vel_down;
        mirror.stats.most_sats    = r.sat_count;
      end

      if (r.sat_count < thresholds.low_sat_limit && !mirror.low_sat_active) begin
        evs.push_back(EV_LOWSAT_BEGIN);
        bump_warn();
        mirror.low_sat_active = 1'b1;
      end else if (r.sat_count >= thresholds.low_sat_limit && mirror.low_sat_active) begin
        evs.push_back(EV_LOWSAT_END);
        mirror.low_sat_active = 1'b0;
      end

      warn_band = r.hdop > thresholds.hdop_warn_level && r.hdop < thresholds.hdop_crit_level;
      crit_band = r.hdop >= thresholds.hdop_crit_level;
      low_band  = r.hdop <= thresholds.hdop_warn_level;

      // Warning into critical leaves the warning band silently but still counts.
      if (warn_band && !mirror.hdop_warn_active) begin
        evs.push_back(EV_WARN_BEGIN);
        bump_warn();
        mirror.hdop_warn_active = 1'b1;
      end else if (crit_band && mirror.hdop_warn_active) begin
        mirror.hdop_warn_active = 1'b0;
        bump_warn();
        bump_crit();
      end else if (low_band && mirror.hdop_warn_active) begin
        evs.push_back(EV_WARN_END);
        mirror.hdop_warn_active = 1'b0;
      end

      // Dropping from critical to warning repeats the warning begin.
      if (crit_band && !mirror.hdop_crit_active) begin
        evs.push_back(EV_CRIT_BEGIN);
        bump_warn();
        bump_crit();
        mirror.hdop_crit_active = 1'b1;
      end else if (warn_band && mirror.hdop_crit_active) begin
        evs.push_back(EV_CRIT_END);
        mirror.hdop_crit_active = 1'b0;
        evs.push_back(EV_WARN_BEGIN);
        bump_warn();
        mirror.hdop_warn_active = 1'b1;
      end else if (low_band && mirror.hdop_crit_active) begin
        evs.push_back(EV_CRIT_END);
        mirror.hdop_crit_active = 1'b0;
      end

      if (r.fix_kind < thresholds.min_fix_type && !mirror.fix_lost_active) begin
        evs.push_back(EV_FIXLOSS_BEGIN);
        bump_warn();
        bump_crit();
        mirror.fix_lost_active = 1'b1;
      end else if (r.fix_kind >= thresholds.min_fix_type && mirror.fix_lost_active) begin
        evs.push_back(EV_FIXLOSS_END);
        mirror.fix_lost_active = 1'b0;
      end

      if (r.speed > mirror.stats.peak_speed) mirror.stats.peak_speed = r.speed;
      if ($signed(r.vel_down) < $signed(mirror.stats.peak_climb))
        mirror.stats.peak_climb = r.vel_down;
      if ($signed(r.vel_down) > $signed(mirror.stats.peak_descent))
        mirror.stats.peak_descent = r.vel_down;
      if (r.sat_count > mirror.stats.most_sats) mirror.stats.most_sats = r.sat_count;
      if (r.sat_count < mirror.stats.fewest_sats) mirror.stats.fewest_sats = r.sat_count;
      gain = int'($signed(r.altitude)) - int'($signed(mirror.base_altitude));
      if (gain > 0 && gain > int'(mirror.stats.peak_alt_gain))
        mirror.stats.peak_alt_gain = AltW'(gain);
      if (mirror.stats.records_seen != '1) mirror.stats.records_seen++;

      if (evs.size() == 0) evs.push_back(EV_NONE);
      o.elapsed = r.time_us - mirror.start_time;
      o.stats   = mirror.stats;
      foreach (evs[k]) begin
        o.code = evs[k];
        o.last = (k == evs.size() - 1);
        due_results.push_back(o);
        code_seen[evs[k]]++;
      end
      records++;
    endfunction

    function void compare_field(string name, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      results++;
      if (due_results.size() == 0) begin
        $error("result with no record waiting: event_code %0d", got.code);
        errors++;
      end else begin
        want = due_results.pop_front();
        compare_field("event_code", want.code, got.code);
        compare_field("event_time_us", want.elapsed, got.elapsed);
        compare_field("last_of_run", want.last, got.last);
        compare_field("warn_total", want.stats.warn_total, got.stats.warn_total);
        compare_field("crit_total", want.stats.crit_total, got.stats.crit_total);
        compare_field("peak_speed", want.stats.peak_speed, got.stats.peak_speed);
        compare_field("peak_climb", want.stats.peak_climb, got.stats.peak_climb);
        compare_field("peak_descent", want.stats.peak_descent, got.stats.peak_descent);
        compare_field("most_sats", want.stats.most_sats, got.stats.most_sats);
        compare_field("fewest_sats", want.stats.fewest_sats, got.stats.fewest_sats);
        compare_field("peak_alt_gain", want.stats.peak_alt_gain, got.stats.peak_alt_gain);
        compare_field("records_seen", want.stats.records_seen, got.stats.records_seen);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_wdata;
  logic [TimeW-1:0]    log_clock;
  int unsigned         hold_req;
  int unsigned         holds_served;
  int unsigned         quiet_cycles;
  outcome_t            observed;
  health_scoreboard    sb = new();

  ghem_rec_if rec_ch ();
  ghem_res_if res_ch ();

  gnss_health_event_monitor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .rec_i       (rec_ch),
    .res_o       (res_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic rec_t make_record(bit first, logic [TimeW-1:0] t, int sat, int hdop,
                                       int fix, int spd, int vel, int alt);
    rec_t r;
    r.first_of_log = first;
    r.time_us      = t;
    r.sat_count    = SatW'(sat);
    r.hdop         = HdopW'(hdop);
    r.fix_kind     = FixW'(fix);
    r.speed        = SpeedW'(spd);
    r.vel_down     = VelW'(vel);
    r.altitude     = AltW'(alt);
    return r;
  endfunction

  // Steer the condition fields towards the current thresholds so the latches toggle often.
  function automatic rec_t random_record(bit first);
    rec_t r;
    if ((first && $urandom_range(0, 1) == 0) || $urandom_range(0, 19) == 0)
      log_clock = TimeW'({$urandom, $urandom});
    else if ($urandom_range(0, 24) == 0)
      log_clock = log_clock - $urandom_range(1, 5000);
    else
      log_clock = log_clock + $urandom_range(0, 200000);
    r.first_of_log = first;
    r.time_us      = log_clock;
    case ($urandom_range(0, 6))
      0:       r.sat_count = sb.thresholds.low_sat_limit;
      1:       r.sat_count = sb.thresholds.low_sat_limit - 1'b1;
      2:       r.sat_count = sb.thresholds.low_sat_limit + 1'b1;
      3:       r.sat_count = '0;
      4:       r.sat_count = '1;
      default: r.sat_count = SatW'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0:       r.hdop = sb.thresholds.hdop_warn_level;
      1:       r.hdop = sb.thresholds.hdop_warn_level + 1'b1;
      2:       r.hdop = sb.thresholds.hdop_warn_level - 1'b1;
      3:       r.hdop = sb.thresholds.hdop_crit_level;
      4:       r.hdop = sb.thresholds.hdop_crit_level - 1'b1;
      5:       r.hdop = sb.thresholds.hdop_crit_level + 1'b1;
      6:       r.hdop = '0;
      7:       r.hdop = '1;
      default: r.hdop = HdopW'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       r.fix_kind = sb.thresholds.min_fix_type;
      1:       r.fix_kind = sb.thresholds.min_fix_type - 1'b1;
      default: r.fix_kind = FixW'($urandom_range(0, 7));
    endcase
    r.speed    = ($urandom_range(0, 15) == 0) ? '1 : SpeedW'($urandom_range(0, 65535));
    r.vel_down = VelW'($urandom_range(0, 65535));
    case ($urandom_range(0, 15))
      0:       r.altitude = AltW'(-1048576);
      1:       r.altitude = AltW'(1048575);
      default: r.altitude = AltW'(int'($urandom_range(0, 2000000)) - 1000000);
    endcase
    return r;
  endfunction

  task automatic send_record(rec_t r);
    @(negedge clk_i);
    rec_ch.valid        = 1'b1;
    rec_ch.first_of_log = r.first_of_log;
    rec_ch.time_us      = r.time_us;
    rec_ch.sat_count    = r.sat_count;
    rec_ch.hdop         = r.hdop;
    rec_ch.fix_kind     = r.fix_kind;
    rec_ch.speed        = r.speed;
    rec_ch.vel_down     = r.vel_down;
    rec_ch.altitude     = r.altitude;
    do @(posedge clk_i); while (rec_ch.ready !== 1'b1);
    sb.note_record(r);
  endtask

  task automatic idle_for(int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      rec_ch.valid = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_quiet();
    while (sb.due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    sb.set_threshold(idx, value);
  endtask

  task automatic program_thresholds(logic [CfgW-1:0] sat_lim, logic [CfgW-1:0] warn,
                                    logic [CfgW-1:0] crit, logic [CfgW-1:0] fix_min);
    idle_for(1);
    wait_quiet();
    // let the result buffer settle before touching the thresholds
    repeat (3) @(posedge clk_i);
    write_reg(CFG_LOW_SAT_LIMIT, sat_lim);
    write_reg(CFG_HDOP_WARN_LEVEL, warn);
    write_reg(CFG_HDOP_CRIT_LEVEL, crit);
    write_reg(CFG_MIN_FIX_TYPE, fix_min);
  endtask

  // Random logs in bursts; with squeeze set, stall the receiver once and drain once.
  task automatic run_phase(int unsigned count, bit squeeze);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned log_left;
    bit          opens;
    sent     = 0;
    burst    = 0;
    log_left = 0;
    while (sent < count) begin
      if (squeeze && sent == count / 4) begin
        hold_req++;
        burst = 25;
      end else if (squeeze && sent == count / 2) begin
        idle_for(1);
        wait_quiet();
        burst = 0;
      end
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 29) == 0) gap = $urandom_range(15, 40);
        idle_for(gap);
        burst = $urandom_range(1, 12);
      end
      opens = 1'b0;
      if (log_left == 0) begin
        log_left = $urandom_range(1, 25);
        opens    = ($urandom_range(0, 9) != 0);
      end
      send_record(random_record(opens));
      burst--;
      log_left--;
      sent++;
    end
  endtask

  // Receiver: stall patterns in spans, plus a long hold whenever one is requested.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    res_ch.ready = 1'b0;
    tick = 0;
    forever begin
      if (holds_served < hold_req) begin
        holds_served++;
        repeat (HoldOff) begin
          @(negedge clk_i);
          res_ch.ready = 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          0:       res_ch.ready = 1'b1;
          1:       res_ch.ready = ($urandom_range(0, 1) == 0);
          2:       res_ch.ready = ($urandom_range(0, 3) != 0);
          default: res_ch.ready = (tick % 3 != 0);
        endcase
        if (holds_served < hold_req) break;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      observed.code                = ev_code_e'(res_ch.event_code);
      observed.elapsed             = res_ch.event_time_us;
      observed.last                = res_ch.last_of_run;
      observed.stats.warn_total    = res_ch.warn_total;
      observed.stats.crit_total    = res_ch.crit_total;
      observed.stats.peak_speed    = res_ch.peak_speed;
      observed.stats.peak_climb    = res_ch.peak_climb;
      observed.stats.peak_descent  = res_ch.peak_descent;
      observed.stats.most_sats     = res_ch.most_sats;
      observed.stats.fewest_sats   = res_ch.fewest_sats;
      observed.stats.peak_alt_gain = res_ch.peak_alt_gain;
      observed.stats.records_seen  = res_ch.records_seen;
      sb.check_result(observed);
    end
  end

  always @(posedge clk_i) begin
    if ((rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rec_t opening[$];
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    log_clock           = '0;
    hold_req            = 0;
    holds_served        = 0;
    quiet_cycles        = 0;
    rec_ch.valid        = 1'b0;
    rec_ch.first_of_log = 1'b0;
    rec_ch.time_us      = '0;
    rec_ch.sat_count    = '0;
    rec_ch.hdop         = '0;
    rec_ch.fix_kind     = '0;
    rec_ch.speed        = '0;
    rec_ch.vel_down     = '0;
    rec_ch.altitude     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset thresholds 6/250/500/2; the first three records come before any log start.
    opening.push_back(make_record(0, 48'd1000, 3, 300, 0, 100, -5, 50));
    opening.push_back(make_record(0, 48'd2000, 10, 600, 3, 50, 5, -20));
    opening.push_back(make_record(0, 48'd3000, 6, 500, 2, 10, 0, 0));
    opening.push_back(make_record(1, 48'hFFFF_FFFF_FF00, 20, 65535, 7, 65535, -32768,
                                  -1048576));
    // low-sat, warning, critical recover with repeated warning, fix loss all at once
    opening.push_back(make_record(0, 48'hFFFF_FFFF_FFFF, 2, 251, 0, 0, 32767, 1048575));
    opening.push_back(make_record(0, 48'd10, 255, 250, 7, 1, 0, 0));
    opening.push_back(make_record(0, 48'd0, 0, 0, 0, 2, 1, 1));
    opening.push_back(make_record(0, 48'd100, 6, 499, 2, 3, -1, -1));
    opening.push_back(make_record(0, 48'd200, 6, 65535, 2, 4, 2, 2));
    opening.push_back(make_record(0, 48'd300, 6, 0, 2, 5, 3, 3));
    opening.push_back(make_record(0, 48'd400, 7, 0, 2, 6, 4, 4));
    opening.push_back(make_record(1, 48'd0, 255, 0, 7, 0, 0, 0));
    opening.push_back(make_record(1, 48'hFFFF_FFFF_FFFF, 0, 65535, 0, 65535, 32767, 1048575));
    opening.push_back(make_record(0, 48'h5555_5555_5555, 'hAA, 'h5555, 'b101, 'hAAAA, 'h5555,
                                  'h0AAAAA));
    opening.push_back(make_record(0, 48'hAAAA_AAAA_AAAA, 'h55, 'hAAAA, 'b010, 'h5555, 'hAAAA,
                                  'h155555));
    foreach (opening[i]) begin
      send_record(opening[i]);
      idle_for($urandom_range(0, 2));
    end

    program_thresholds(6, 250, 500, 2);
    run_phase(80, 1);
    program_thresholds(0, 0, 0, 0);
    run_phase(80, 0);
    program_thresholds(255, 65535, 65535, 7);
    run_phase(80, 0);
    // warning level above critical: the warning band is empty
    program_thresholds(12, 600, 300, 4);
    run_phase(80, 0);
    program_thresholds(CfgW'($urandom_range(0, 20)), CfgW'($urandom_range(0, 1000)),
                       CfgW'($urandom_range(1000, 3000)), CfgW'($urandom_range(0, 7)));
    run_phase(80, 0);
    // full-width data: the narrow registers keep only their low bits
    program_thresholds(CfgW'($urandom_range(0, 65535)), CfgW'($urandom_range(0, 65535)),
                       CfgW'($urandom_range(0, 65535)), CfgW'($urandom_range(0, 65535)));
    run_phase(80, 0);

    idle_for(1);
    wait_quiet();
    repeat (8) @(posedge clk_i);
    $display("covered %0d records and %0d results over 7 threshold settings, %0d errors",
             sb.records, sb.results, sb.errors);
    $display("event codes 0..8 expected: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.code_seen[0], sb.code_seen[1], sb.code_seen[2], sb.code_seen[3],
             sb.code_seen[4], sb.code_seen[5], sb.code_seen[6], sb.code_seen[7],
             sb.code_seen[8]);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
